/* src/multi_endpoint_ring_fifo_top_macros.svh */
// assertion macros for the multi-endpoint ring fifo
// no dependencies; included by the modules that check their own logic
`ifndef MULTI_ENDPOINT_RING_FIFO_TOP_MACROS_SVH
`define MULTI_ENDPOINT_RING_FIFO_TOP_MACROS_SVH

// same-cycle implication
`define MERF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("merf same-cycle check failed");

// next-cycle implication
`define MERF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("merf next-cycle check failed");

`endif

/* src/merf_pkg.sv */
// shared constants, codes, types and helpers for the multi-endpoint ring fifo
// no dependencies
`default_nettype none

package merf_pkg;

	localparam int NUM_DATA_ENDPOINTS = 4;
	localparam int FIFO_DEPTH         = 64;
	localparam int NUM_EP             = NUM_DATA_ENDPOINTS + 1;

	localparam int PTR_W    = $clog2(FIFO_DEPTH);
	localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);
	localparam int EP_IDX_W = $clog2(NUM_EP);
	localparam int MEM_DEPTH = NUM_EP * FIFO_DEPTH;
	localparam int ADDR_W   = $clog2(MEM_DEPTH);

	// fixed field widths
	localparam int ACT_W  = 2;
	localparam int EP_W   = 3;
	localparam int DATA_W = 8;
	localparam int FILL_W = 7;
	localparam int STAT_W = 2;
	localparam int MASK_W = 5;

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_QUERY = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_RD_EMPTY = 2'd1,
		STATUS_WR_FULL  = 2'd2
	} status_t;

	// result fields except the ram read data
	typedef struct packed {
		logic              rd_ok;
		logic [EP_W-1:0]   pend;
		logic              found;
		logic [FILL_W-1:0] fill;
		status_t           status;
	} result_t;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
		logic [PTR_W-1:0] nxt;
		nxt = (ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
		return nxt;
	endfunction

	function automatic logic [ADDR_W-1:0] mem_addr(input logic [EP_IDX_W-1:0] ep,
		input logic [PTR_W-1:0] ptr);
		logic [ADDR_W-1:0] base;
		base = ADDR_W'(ep) * ADDR_W'(FIFO_DEPTH);
		return base + ADDR_W'(ptr);
	endfunction

endpackage

`default_nettype wire

/* src/merf_ram.sv */
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
`default_nettype none

module merf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/multi_endpoint_ring_fifo_top.sv */
// multi-endpoint byte ring fifo: per-endpoint pointers and counts, shared byte ram
// depends on merf_pkg, merf_ram and multi_endpoint_ring_fifo_top_macros.svh
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------------
//  in      | in_valid / in_stall   | action, endpoint, data_in, direction
//  out     | out_valid / out_stall | data_out, pending_endpoint, found, fill_level,
//          |                       | status
//  cfg     | cfg_wr_en             | cfg_wr_data (endpoint direction mask)
//
// one request per cycle while in_stall is low; each result passes through the ram stage (the
// registered read of the byte ram) and then the output register after its request is taken.
// pointers and counts update in the accept cycle, so back-to-back requests to one
// endpoint see each other; a ram read of a slot always follows the ram write that filled it.
// arst_n clears all pointers, counts and the mask; ram contents are undefined.
// input stalls only while a result waits in the ram stage and the output is stalled.
`default_nettype none

`include "multi_endpoint_ring_fifo_top_macros.svh"

module multi_endpoint_ring_fifo_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          cfg_wr_en,
	input  wire logic [merf_pkg::MASK_W-1:0]   cfg_wr_data,

	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire logic [merf_pkg::ACT_W-1:0]    action,
	input  wire logic [merf_pkg::EP_W-1:0]     endpoint,
	input  wire logic [merf_pkg::DATA_W-1:0]   data_in,
	input  wire logic                          direction,

	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic [merf_pkg::DATA_W-1:0]   data_out,
	output      logic [merf_pkg::EP_W-1:0]     pending_endpoint,
	output      logic                          found,
	output      logic [merf_pkg::FILL_W-1:0]   fill_level,
	output      logic [merf_pkg::STAT_W-1:0]   status
);

	logic [merf_pkg::MASK_W-1:0] mask_q;
	logic [merf_pkg::PTR_W-1:0]  rd_ptr_q [merf_pkg::NUM_EP];
	logic [merf_pkg::PTR_W-1:0]  wr_ptr_q [merf_pkg::NUM_EP];
	logic [merf_pkg::CNT_W-1:0]  cnt_q    [merf_pkg::NUM_EP];

	logic                           valid_s1;
	merf_pkg::result_t              res_s1;
	logic                           out_valid_q;
	merf_pkg::result_t              out_res_q;
	logic [merf_pkg::DATA_W-1:0]    out_data_q;

	logic                           in_acc;
	logic                           adv_s1;
	logic                           ep_ok;
	logic [merf_pkg::EP_IDX_W-1:0]  ep_idx;
	logic [merf_pkg::CNT_W-1:0]     cur_cnt;
	logic [merf_pkg::PTR_W-1:0]     cur_rd;
	logic [merf_pkg::PTR_W-1:0]     cur_wr;
	logic                           is_full;
	logic                           is_empty;
	logic                           do_wr;
	logic                           do_rd;
	logic                           do_clr;
	logic [merf_pkg::CNT_W-1:0]     nxt_cnt;
	logic [merf_pkg::NUM_EP-1:0]    ep_dir;
	merf_pkg::result_t              res_d;
	logic [merf_pkg::DATA_W-1:0]    ram_rdata;

	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	// direction bits above the register width read as zero
	assign ep_dir = merf_pkg::NUM_EP'(mask_q);

	always_comb begin
		ep_ok    = (int'(endpoint) < merf_pkg::NUM_EP);
		ep_idx   = merf_pkg::EP_IDX_W'(endpoint);
		cur_cnt  = ep_ok ? cnt_q[ep_idx] : '0;
		cur_rd   = ep_ok ? rd_ptr_q[ep_idx] : '0;
		cur_wr   = ep_ok ? wr_ptr_q[ep_idx] : '0;
		is_full  = (cur_cnt == merf_pkg::CNT_W'(merf_pkg::FIFO_DEPTH));
		is_empty = (cur_cnt == '0);
		do_wr    = ep_ok && (action == merf_pkg::ACT_WRITE) && !is_full;
		do_rd    = ep_ok && (action == merf_pkg::ACT_READ) && !is_empty;
		do_clr   = ep_ok && (action == merf_pkg::ACT_CLEAR);
	end

	always_comb begin
		priority if (do_wr) begin
			nxt_cnt = cur_cnt + merf_pkg::CNT_W'(1);
		end else if (do_rd) begin
			nxt_cnt = cur_cnt - merf_pkg::CNT_W'(1);
		end else if (do_clr) begin
			nxt_cnt = '0;
		end else begin
			nxt_cnt = cur_cnt;
		end
	end

	// result fields; the scan runs high to low so the lowest match wins
	always_comb begin
		res_d        = '0;
		res_d.rd_ok  = do_rd;
		res_d.fill   = merf_pkg::FILL_W'(nxt_cnt);
		res_d.status = merf_pkg::STATUS_OK;
		if (ep_ok && (action == merf_pkg::ACT_WRITE) && is_full) begin
			res_d.status = merf_pkg::STATUS_WR_FULL;
		end
		if (ep_ok && (action == merf_pkg::ACT_READ) && is_empty) begin
			res_d.status = merf_pkg::STATUS_RD_EMPTY;
		end
		if (action == merf_pkg::ACT_QUERY) begin
			for (int i = merf_pkg::NUM_EP - 1; i >= 1; i--) begin
				if ((ep_dir[i] == direction) && (cnt_q[i] != '0)) begin
					res_d.pend  = merf_pkg::EP_W'(i);
					res_d.found = 1'b1;
				end
			end
		end
	end

	merf_ram #(
		.WIDTH(merf_pkg::DATA_W),
		.DEPTH(merf_pkg::MEM_DEPTH)
	) u_byte_ram (
		.clk   (clk),
		.we    (in_acc && do_wr),
		.waddr (merf_pkg::mem_addr(ep_idx, cur_wr)),
		.wdata (data_in),
		.re    (in_acc && do_rd),
		.raddr (merf_pkg::mem_addr(ep_idx, cur_rd)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_wr_en) begin
			mask_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < merf_pkg::NUM_EP; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
				cnt_q[i]    <= '0;
			end
		end else if (in_acc) begin
			if (do_wr) begin
				wr_ptr_q[ep_idx] <= merf_pkg::ptr_inc(cur_wr);
				cnt_q[ep_idx]    <= nxt_cnt;
			end
			if (do_rd) begin
				rd_ptr_q[ep_idx] <= merf_pkg::ptr_inc(cur_rd);
				cnt_q[ep_idx]    <= nxt_cnt;
			end
			if (do_clr) begin
				rd_ptr_q[ep_idx] <= '0;
				wr_ptr_q[ep_idx] <= '0;
				cnt_q[ep_idx]    <= '0;
			end
		end
	end

	// ram stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_s1 <= res_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_res_q  <= res_s1;
			out_data_q <= res_s1.rd_ok ? ram_rdata : '0;
		end
	end

	assign out_valid        = out_valid_q;
	assign data_out         = out_data_q;
	assign pending_endpoint = out_res_q.pend;
	assign found            = out_res_q.found;
	assign fill_level       = out_res_q.fill;
	assign status           = out_res_q.status;

	`MERF_ASSERT_IMPL(a_cnt_bound, clk, arst_n, in_valid && ep_ok, cur_cnt <= merf_pkg::CNT_W'(merf_pkg::FIFO_DEPTH))
	`MERF_ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, valid_s1 && out_valid_q)
	`MERF_ASSERT_NEXT(a_full_flag, clk, arst_n, in_acc && ep_ok && (action == merf_pkg::ACT_WRITE) && is_full, res_s1.status == merf_pkg::STATUS_WR_FULL)
	`MERF_ASSERT_IMPL(a_found_nonzero, clk, arst_n, valid_s1 && res_s1.found, res_s1.pend != '0)

endmodule

`default_nettype wire

/* tb/multi_endpoint_ring_fifo_top_tb.sv */
// self-checking testbench for the multi-endpoint ring fifo: directed, full/wrap and random
// request traffic checked against a per-endpoint ring predictor; needs merf_pkg and the rtl
module multi_endpoint_ring_fifo_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import merf_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_COUNT  = 8;
	localparam int PHASE_ITEMS  = 180;
	localparam int PRINT_LIMIT  = 100;

	typedef struct {
		logic [DATA_W-1:0] data;
		logic [EP_W-1:0]   pend;
		logic              found;
		logic [FILL_W-1:0] fill;
		status_t           status;
	} fifo_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [MASK_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [ACT_W-1:0] action = '0;
	logic [EP_W-1:0] endpoint = '0;
	logic [DATA_W-1:0] data_in = '0;
	logic direction = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [DATA_W-1:0] data_out;
	logic [EP_W-1:0] pending_endpoint;
	logic found;
	logic [FILL_W-1:0] fill_level;
	logic [STAT_W-1:0] status;

	// predictor state
	logic [DATA_W-1:0] ring_mem [NUM_EP][FIFO_DEPTH];
	int rd_ptr [NUM_EP];
	int wr_ptr [NUM_EP];
	int ep_count [NUM_EP];
	logic [MASK_W-1:0] dir_mask = '0;

	fifo_reply_t reply_queue [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_max = 0;
	int stall_mode = 0;
	int stall_run = 0;

	multi_endpoint_ring_fifo_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.endpoint(endpoint),
		.data_in(data_in),
		.direction(direction),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_out(data_out),
		.pending_endpoint(pending_endpoint),
		.found(found),
		.fill_level(fill_level),
		.status(status)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver stall pattern: none, scattered, or long runs
	always @(posedge clk) begin
		if (stall_run > 0) begin
			stall_run <= stall_run - 1;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				1: begin
					out_stall <= ($urandom_range(0, 3) == 0);
				end
				2: begin
					if ($urandom_range(0, 15) == 0) begin
						stall_run <= $urandom_range(1, 20);
						out_stall <= 1'b1;
					end else begin
						out_stall <= 1'b0;
					end
				end
				default: begin
					out_stall <= 1'b0;
				end
			endcase
		end
	end

	function automatic fifo_reply_t predict_reply(input action_t act, input logic [EP_W-1:0] ep,
		input logic [DATA_W-1:0] din, input logic qdir);
		fifo_reply_t r;
		int i;
		r.data = '0;
		r.pend = '0;
		r.found = 1'b0;
		r.fill = '0;
		r.status = STATUS_OK;
		if (act == ACT_QUERY) begin
			// first data endpoint with matching direction and data wins
			for (i = 1; i < NUM_EP; i++) begin
				if (!r.found && dir_mask[i] == qdir && ep_count[i] != 0) begin
					r.pend = EP_W'(i);
					r.found = 1'b1;
				end
			end
		end else if (ep < NUM_EP) begin
			case (act)
				ACT_WRITE: begin
					if (ep_count[ep] >= FIFO_DEPTH) begin
						r.status = STATUS_WR_FULL;
					end else begin
						ring_mem[ep][wr_ptr[ep]] = din;
						wr_ptr[ep] = (wr_ptr[ep] + 1) % FIFO_DEPTH;
						ep_count[ep]++;
					end
				end
				ACT_READ: begin
					if (ep_count[ep] == 0) begin
						r.status = STATUS_RD_EMPTY;
					end else begin
						r.data = ring_mem[ep][rd_ptr[ep]];
						rd_ptr[ep] = (rd_ptr[ep] + 1) % FIFO_DEPTH;
						ep_count[ep]--;
					end
				end
				default: begin
					rd_ptr[ep] = 0;
					wr_ptr[ep] = 0;
					ep_count[ep] = 0;
				end
			endcase
		end
		if (ep < NUM_EP)
			r.fill = FILL_W'(ep_count[ep]);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatch_count < PRINT_LIMIT)
			$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_results
		fifo_reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (reply_queue.size() == 0) begin
				report_mismatch("result with no request outstanding", 0, 0);
			end else begin
				want = reply_queue.pop_front();
				if (data_out !== want.data)
					report_mismatch("data_out", data_out, want.data);
				if (pending_endpoint !== want.pend)
					report_mismatch("pending_endpoint", pending_endpoint, want.pend);
				if (found !== want.found)
					report_mismatch("found", found, want.found);
				if (fill_level !== want.fill)
					report_mismatch("fill_level", fill_level, want.fill);
				if (status !== want.status)
					report_mismatch("status", status, want.status);
			end
		end
	end

	task automatic send_request(input action_t act, input logic [EP_W-1:0] ep,
		input logic [DATA_W-1:0] din, input logic qdir);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		action <= act;
		endpoint <= ep;
		data_in <= din;
		direction <= qdir;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		reply_queue.push_back(predict_reply(act, ep, din, qdir));
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain_requests();
		in_valid <= 1'b0;
		while (reply_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_direction_mask(input logic [MASK_W-1:0] mask);
		drain_requests();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mask;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		dir_mask = mask;
	endtask

	task automatic test_directed();
		gap_max = 2;
		stall_mode = 1;
		set_direction_mask('0);
		send_request(ACT_QUERY, 3'd0, 8'h00, 1'b0);
		send_request(ACT_QUERY, 3'd0, 8'h00, 1'b1);
		send_request(ACT_WRITE, 3'd1, 8'h00, 1'b0);
		send_request(ACT_WRITE, 3'd1, 8'hFF, 1'b1);
		send_request(ACT_WRITE, 3'd4, 8'hA5, 1'b0);
		send_request(ACT_WRITE, 3'd0, 8'h5A, 1'b0);
		// out-of-range endpoints do nothing
		send_request(ACT_WRITE, 3'd7, 8'hFF, 1'b1);
		send_request(ACT_READ, 3'd6, 8'h00, 1'b0);
		send_request(ACT_CLEAR, 3'd5, 8'h00, 1'b0);
		send_request(ACT_QUERY, 3'd7, 8'h00, 1'b0);
		send_request(ACT_QUERY, 3'd1, 8'h00, 1'b1);
		send_request(ACT_READ, 3'd1, 8'h00, 1'b0);
		send_request(ACT_READ, 3'd1, 8'h00, 1'b0);
		send_request(ACT_READ, 3'd1, 8'h00, 1'b0);
		send_request(ACT_READ, 3'd0, 8'h00, 1'b0);
		send_request(ACT_QUERY, 3'd4, 8'h00, 1'b0);
		send_request(ACT_CLEAR, 3'd4, 8'h00, 1'b0);
		send_request(ACT_QUERY, 3'd4, 8'h00, 1'b0);
		send_request(ACT_READ, 3'd4, 8'h00, 1'b0);
		send_request(ACT_WRITE, 3'd2, 8'h3C, 1'b0);
		send_request(ACT_WRITE, 3'd3, 8'hC3, 1'b0);
		set_direction_mask('1);
		send_request(ACT_QUERY, 3'd2, 8'h00, 1'b1);
		send_request(ACT_QUERY, 3'd2, 8'h00, 1'b0);
		set_direction_mask(5'b10100);
		send_request(ACT_QUERY, 3'd3, 8'h00, 1'b1);
		send_request(ACT_QUERY, 3'd3, 8'h00, 1'b0);
		send_request(ACT_CLEAR, 3'd2, 8'h00, 1'b0);
		send_request(ACT_CLEAR, 3'd3, 8'h00, 1'b0);
	endtask

	// offset the pointers, then fill past full and drain past empty so both wrap
	task automatic test_full_and_wrap(input logic [EP_W-1:0] ep, input int offset);
		int i;
		gap_max = 0;
		stall_mode = 2;
		for (i = 0; i < offset; i++)
			send_request(ACT_WRITE, ep, 8'($urandom_range(0, 255)), 1'b0);
		for (i = 0; i < offset; i++)
			send_request(ACT_READ, ep, 8'h00, 1'b0);
		for (i = 0; i < FIFO_DEPTH + 2; i++)
			send_request(ACT_WRITE, ep, 8'($urandom_range(0, 255)), 1'b0);
		send_request(ACT_QUERY, ep, 8'h00, dir_mask[ep]);
		for (i = 0; i < FIFO_DEPTH + 2; i++)
			send_request(ACT_READ, ep, 8'h00, 1'b0);
	endtask

	task automatic test_random_traffic();
		int phase;
		int n;
		int sel;
		int hot_ep;
		int wr_pct;
		action_t act;
		logic [EP_W-1:0] ep;
		int write_bias [PHASE_COUNT] = '{50, 85, 20, 95, 60, 30, 75, 50};
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			if (phase == 0)
				set_direction_mask('0);
			else if (phase == 1)
				set_direction_mask('1);
			else
				set_direction_mask(MASK_W'($urandom_range(0, 31)));
			wr_pct = write_bias[phase];
			hot_ep = $urandom_range(0, NUM_EP - 1);
			gap_max = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 3 : 8);
			stall_mode = (phase + 1) % 3;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 8)
					act = ACT_QUERY;
				else if (sel < 10)
					act = ACT_CLEAR;
				else if ($urandom_range(0, 99) < wr_pct)
					act = ACT_WRITE;
				else
					act = ACT_READ;
				sel = $urandom_range(0, 99);
				if (sel < 5)
					ep = EP_W'($urandom_range(NUM_EP, 7));
				else if (sel < 60)
					ep = EP_W'(hot_ep);
				else
					ep = EP_W'($urandom_range(0, NUM_EP - 1));
				send_request(act, ep, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		int i;
		for (i = 0; i < NUM_EP; i++) begin
			rd_ptr[i] = 0;
			wr_ptr[i] = 0;
			ep_count[i] = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_and_wrap(3'd3, 0);
		test_full_and_wrap(3'd2, 37);
		test_random_traffic();
		drain_requests();
		repeat (6) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/merf_pkg.sv
src/merf_ram.sv
src/multi_endpoint_ring_fifo_top.sv
tb/multi_endpoint_ring_fifo_top_tb.sv
